>>> rtl/dte_pkg.sv
// shared types, constants and the character lookup for the digest text encoder
package dte_pkg;

    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam logic [7:0] HEX_PREFIX_RESET = 8'd2;
    localparam logic [7:0] BYTE_INDEX_MAX = 8'd255;
    localparam logic [3:0] GROUP_BITS = 4'd5;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [2:0][4:0] digits;
        logic [1:0]      count;
        logic            last;
    } dte_job_t;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [JOB_PTR_W:0]   level;
    } dte_fifo_status_t;

    typedef struct packed {
        logic [7:0] byte_index;
        logic [2:0] leftover_count;
    } dte_front_status_t;

    function automatic logic [7:0] digit_char(input logic [4:0] digit);
        logic [7:0] c;
        if (digit < 5'd10)
            c = 8'h30 + {3'b000, digit};
        else
            c = 8'h61 + {3'b000, digit} - 8'd10;
        return c;
    endfunction

endpackage

>>> rtl/dte_front.sv
// front end: byte accept, hex or base32 classification, character job build
module dte_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    input  logic                       cfg_wr_en,
    input  logic [7:0]                 cfg_wr_data,
    input  logic                       fifo_full,
    output logic                       push,
    output dte_pkg::dte_job_t          job,
    output dte_pkg::dte_front_status_t status
);

    logic [7:0]  hex_prefix_reg;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [3:0]  leftover_bits_reg, leftover_bits_next;
    logic [2:0]  leftover_count_reg, leftover_count_next;

    logic        accept;
    logic        is_hex;
    logic [11:0] acc;
    logic [11:0] rem_acc;
    logic [3:0]  cnt;
    logic [3:0]  rem;
    logic        two_groups;
    logic [4:0]  group_a;
    logic [4:0]  group_b;
    logic [4:0]  flush_digit;
    logic        do_flush;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign push     = accept;
    assign is_hex   = byte_index_reg < hex_prefix_reg;

    assign status.byte_index     = byte_index_reg;
    assign status.leftover_count = leftover_count_reg;

    always_comb
    begin
        acc         = {leftover_bits_reg, data_byte};
        cnt         = {1'b0, leftover_count_reg} + dte_pkg::BYTE_BITS;
        two_groups  = cnt >= (dte_pkg::GROUP_BITS << 1);
        group_a     = 5'(acc >> (cnt - dte_pkg::GROUP_BITS));
        group_b     = 5'(acc >> (cnt - (dte_pkg::GROUP_BITS << 1)));
        rem         = two_groups ? cnt - (dte_pkg::GROUP_BITS << 1) : cnt - dte_pkg::GROUP_BITS;
        rem_acc     = acc & ((12'd1 << rem) - 12'd1);
        flush_digit = 5'(rem_acc << (dte_pkg::GROUP_BITS - rem));
        do_flush    = last_byte && (rem != 4'd0);

        job.digits = '0;
        job.last   = last_byte;
        if (is_hex)
        begin
            job.digits[0] = {1'b0, data_byte[7:4]};
            job.digits[1] = {1'b0, data_byte[3:0]};
            job.count     = 2'd2;
        end
        else
        begin
            job.digits[0] = group_a;
            if (two_groups)
            begin
                job.digits[1] = group_b;
                job.count     = 2'd2;
            end
            else
            begin
                job.count = 2'd1;
            end
            if (do_flush)
            begin
                job.digits[job.count] = flush_digit;
                job.count             = job.count + 2'd1;
            end
        end
    end

    always_comb
    begin
        byte_index_next     = byte_index_reg;
        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                byte_index_next     = '0;
                leftover_bits_next  = '0;
                leftover_count_next = '0;
            end
            else
            begin
                if (byte_index_reg != dte_pkg::BYTE_INDEX_MAX)
                    byte_index_next = byte_index_reg + 8'd1;
                if (!is_hex)
                begin
                    leftover_bits_next  = 4'(rem_acc);
                    leftover_count_next = 3'(rem);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_prefix_reg     <= dte_pkg::HEX_PREFIX_RESET;
            byte_index_reg     <= '0;
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                hex_prefix_reg <= cfg_wr_data;
            byte_index_reg     <= byte_index_next;
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
        end
    end

endmodule

>>> rtl/dte_fifo.sv
// short job queue between front end and character emitter
module dte_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  dte_pkg::dte_job_t         push_job,
    input  logic                      pop,
    output dte_pkg::dte_job_t         head_job,
    output dte_pkg::dte_fifo_status_t status
);

    dte_pkg::dte_job_t              mem_reg [dte_pkg::JOB_DEPTH];
    logic [dte_pkg::JOB_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [dte_pkg::JOB_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [dte_pkg::JOB_PTR_W:0]    level_reg, level_next;

    assign head_job     = mem_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = level_reg == '0;
    assign status.full  = level_reg == (dte_pkg::JOB_PTR_W + 1)'(dte_pkg::JOB_DEPTH);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        unique case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

>>> rtl/dte_back.sv
// back end: job characters into the output register, one per cycle unless stalled
module dte_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dte_pkg::dte_job_t head_job,
    input  logic              fifo_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        text_char,
    output logic              last_char
);

    logic [1:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] text_char_reg;
    logic       last_char_reg;
    logic       load;
    logic       job_end;

    assign load    = !fifo_empty && (!out_valid_reg || !out_stall);
    assign job_end = pos_reg == (head_job.count - 2'd1);
    assign pop     = load && job_end;

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (load)
            pos_next = job_end ? 2'd0 : pos_reg + 2'd1;
        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            text_char_reg <= dte_pkg::digit_char(head_job.digits[pos_reg]);
            last_char_reg <= head_job.last && job_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/digest_text_encoder_unit.sv
// top level of the digest text encoder: front end, job queue, character emitter
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_stall, data_byte,     | beat in
//          | last_byte                          |
//  out     | out_valid, out_stall, text_char,   | beat out
//          | last_char                          |
//  cfg     | cfg_wr_en, cfg_wr_data             | write only
//
// a byte is taken in one cycle whenever the four-entry job queue has room
// each byte yields one to three characters, one per cycle unless stalled, so the
// emitter sets the rate: two characters per hex byte, on average 1.6 per base32
// byte; the first character passes the job queue and then the output register
// reset clears stream state, queue and output; hex prefix length returns to two
// out_stall holds the output register; the queue lets input run ahead
module digest_text_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_char,
    output logic       last_char,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    dte_pkg::dte_job_t          push_job;
    dte_pkg::dte_job_t          head_job;
    dte_pkg::dte_fifo_status_t  fifo_status;
    dte_pkg::dte_front_status_t front_status;
    logic                       push;
    logic                       pop;

    dte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_full   (fifo_status.full),
        .push        (push),
        .job         (push_job),
        .status      (front_status)
    );

    dte_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (fifo_status)
    );

    dte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .fifo_empty (fifo_status.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .text_char  (text_char),
        .last_char  (last_char)
    );

    a_leftover_range: assert property (@(posedge clk) disable iff (!rst_n)
        front_status.leftover_count <= 3'd4)
        else $error("leftover bit count out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=>
            (front_status.byte_index == 8'd0 && front_status.leftover_count == 3'd0))
        else $error("stream state not cleared after last byte");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.level <= (dte_pkg::JOB_PTR_W + 1)'(dte_pkg::JOB_DEPTH))
        else $error("job queue level beyond depth");

    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        !fifo_status.empty |-> head_job.count != 2'd0)
        else $error("queued job without characters");

endmodule
